@@ src/tcp_half_open_tracker_macros.svh @@
// assertion macros for the half-open connection tracker
// expects clk and rst in the scope of use
`ifndef TCP_HALF_OPEN_TRACKER_MACROS_SVH
`define TCP_HALF_OPEN_TRACKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define THO_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// condition holds at every edge out of reset
`define THO_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tracker assertion failed");

`endif

@@ src/tho_pkg.sv @@
// shared constants, codes and structs of the half-open connection tracker
// no dependencies
`default_nettype none

package tho_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int COUNT_BITS    = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam int S_FIELD_BITS  = 8 + 32 + 32 + 16 + 16 + 32;
  localparam int S_TDATA_W     = ((S_FIELD_BITS + 7) / 8) * 8;
  localparam int M_FIELD_BITS  = 32 + 32 + 16 + 16 + 16 + 32 + 5 + 32;
  localparam int M_TDATA_W     = ((M_FIELD_BITS + 7) / 8) * 8;
  localparam int M_PAD_W       = M_TDATA_W - M_FIELD_BITS;

  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_MONITOR_ENABLE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_AGE_THRESHOLD  = 1'b1;
  localparam logic [15:0] AGE_THRESHOLD_RESET = 16'd60;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_SYN    = 2'd1,
    OP_SYNACK = 2'd2,
    OP_SWEEP  = 2'd3
  } op_kind_t;

  typedef enum logic [2:0] {
    KIND_IGNORED    = 3'd0,
    KIND_ADDED      = 3'd1,
    KIND_MERGED     = 3'd2,
    KIND_DELETED    = 3'd3,
    KIND_DEL_MISS   = 3'd4,
    KIND_FULL       = 3'd5,
    KIND_EXPIRED    = 3'd6,
    KIND_SWEEP_DONE = 3'd7
  } res_kind_t;

  // classified command, key already in server/client order
  typedef struct packed {
    op_kind_t    op;
    logic [31:0] listen_ip;
    logic [31:0] remote_ip;
    logic [15:0] listen_port;
    logic [15:0] remote_port;
    logic [31:0] now_sec;
  } op_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [31:0] listen_ip;
    logic [31:0] remote_ip;
    logic [15:0] listen_port;
    logic [15:0] remote_port;
    logic [15:0] syn_count;
    logic [31:0] start_sec;
    logic [4:0]  entries_in_use;
    logic [31:0] detected_total;
    logic        last;
  } res_t;

  typedef struct packed {
    logic              busy;
    logic [USED_W-1:0] used_count;
  } back_status_t;

endpackage

`default_nettype wire

@@ src/tho_front.sv @@
// front end: accepts stream transactions and classifies them into commands
// depends on tho_pkg
`default_nettype none

module tho_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tho_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          monitor_enable,
  input  logic                          queue_full,
  output logic                          push,
  output tho_pkg::op_t                  push_op
);
  import tho_pkg::*;

  logic [7:0]  flags;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] now_sec;

  assign flags    = s_tdata[7:0];
  assign src_ip   = s_tdata[39:8];
  assign dst_ip   = s_tdata[71:40];
  assign src_port = s_tdata[87:72];
  assign dst_port = s_tdata[103:88];
  assign now_sec  = s_tdata[135:104];

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_op.now_sec = now_sec;
    // default: server is the source side
    push_op.listen_ip   = src_ip;
    push_op.remote_ip   = dst_ip;
    push_op.listen_port = src_port;
    push_op.remote_port = dst_port;
    priority if (s_tuser) begin
      push_op.op = OP_SWEEP;
    end else if (!monitor_enable) begin
      push_op.op = OP_IGNORE;
    end else if (flags == FLAG_SYN) begin
      // client to server: server is the destination
      push_op.op          = OP_SYN;
      push_op.listen_ip   = dst_ip;
      push_op.remote_ip   = src_ip;
      push_op.listen_port = dst_port;
      push_op.remote_port = src_port;
    end else if (((flags & FLAG_SYN) != 8'd0) && ((flags & FLAG_ACK) != 8'd0)) begin
      push_op.op = OP_SYNACK;
    end else begin
      push_op.op = OP_IGNORE;
    end
  end

endmodule

`default_nettype wire

@@ src/tho_queue.sv @@
// short command queue between front and back end
// depends on tho_pkg
`default_nettype none

module tho_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tho_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output tho_pkg::op_t head
);
  import tho_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

@@ src/tho_back.sv @@
// back end: connection table, command execution, sweep walk, result register
// depends on tho_pkg
`default_nettype none

module tho_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           age_threshold_sec,
  input  logic                  q_empty,
  input  tho_pkg::op_t          q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output tho_pkg::res_t         res,
  output tho_pkg::back_status_t status
);
  import tho_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PKT   = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  op_t                     cur;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_next;
  logic [USED_W-1:0]       used_count;
  logic [USED_W-1:0]       used_count_next;
  logic [31:0]             detected;
  logic [31:0]             detected_next;
  res_t                    res_next;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [31:0]              e_sip   [TABLE_ENTRIES];
  logic [31:0]              e_cip   [TABLE_ENTRIES];
  logic [15:0]              e_sport [TABLE_ENTRIES];
  logic [15:0]              e_cport [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]    e_cnt   [TABLE_ENTRIES];
  logic [31:0]              e_start [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_idx;
  logic                     free_any;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         rd_idx;
  logic [COUNT_BITS-1:0]    rd_cnt;
  logic [COUNT_BITS-1:0]    cnt_inc;
  logic [31:0]              rd_start;
  logic                     aged;
  logic                     out_free;
  logic                     pkt_go;
  logic                     do_add;
  logic                     do_merge;
  logic                     do_del;
  logic                     sweep_exp;
  logic                     sweep_step;
  logic                     done_go;
  logic                     res_load;

  assign out_free = !res_valid || res_ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  // parallel key compare and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (e_sip[i] == cur.listen_ip) && (e_cip[i] == cur.remote_ip) &&
                   (e_sport[i] == cur.listen_port) && (e_cport[i] == cur.remote_port);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = !(&valid);
  assign rd_idx   = (state == ST_SWEEP) ? idx : hit_idx;
  assign rd_cnt   = e_cnt[rd_idx];
  assign rd_start = e_start[rd_idx];
  assign cnt_inc  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign aged     = valid[idx] && (cur.now_sec >= rd_start) &&
                    ((cur.now_sec - rd_start) >= {16'd0, age_threshold_sec});

  assign pkt_go     = (state == ST_PKT) && out_free;
  assign do_merge   = pkt_go && (cur.op == OP_SYN) && hit_any;
  assign do_add     = pkt_go && (cur.op == OP_SYN) && !hit_any && free_any;
  assign do_del     = pkt_go && (cur.op == OP_SYNACK) && hit_any;
  assign sweep_exp  = (state == ST_SWEEP) && aged && out_free;
  assign sweep_step = (state == ST_SWEEP) && (!aged || out_free);
  assign done_go    = (state == ST_DONE) && out_free;
  assign res_load   = pkt_go || sweep_exp || done_go;

  always_comb begin
    used_count_next = used_count;
    if (do_add) begin
      used_count_next = used_count + USED_W'(1);
    end else if ((do_del || sweep_exp) && (used_count != '0)) begin
      used_count_next = used_count - USED_W'(1);
    end
    detected_next = detected;
    if (sweep_exp && (detected != '1)) begin
      detected_next = detected + 32'd1;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          state_next = (q_head.op == OP_SWEEP) ? ST_SWEEP : ST_PKT;
          idx_next   = '0;
        end
      end
      ST_PKT: begin
        if (pkt_go) begin
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sweep_step) begin
          if (idx == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_next = ST_DONE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // table fields of the result read before this cycle's update; counters after it
  always_comb begin
    res_next                = '0;
    res_next.kind           = KIND_IGNORED;
    res_next.last           = 1'b1;
    res_next.entries_in_use = 5'(used_count_next);
    res_next.detected_total = detected_next;
    unique case (state)
      ST_PKT: begin
        unique case (cur.op)
          OP_SYN: begin
            if (hit_any) begin
              res_next.kind        = KIND_MERGED;
              res_next.listen_ip   = e_sip[hit_idx];
              res_next.remote_ip   = e_cip[hit_idx];
              res_next.listen_port = e_sport[hit_idx];
              res_next.remote_port = e_cport[hit_idx];
              res_next.syn_count   = 16'(cnt_inc);
              res_next.start_sec   = rd_start;
            end else begin
              res_next.kind        = free_any ? KIND_ADDED : KIND_FULL;
              res_next.listen_ip   = cur.listen_ip;
              res_next.remote_ip   = cur.remote_ip;
              res_next.listen_port = cur.listen_port;
              res_next.remote_port = cur.remote_port;
              res_next.syn_count   = 16'(COUNT_BITS'(1));
              res_next.start_sec   = cur.now_sec;
            end
          end
          OP_SYNACK: begin
            if (hit_any) begin
              res_next.kind        = KIND_DELETED;
              res_next.listen_ip   = e_sip[hit_idx];
              res_next.remote_ip   = e_cip[hit_idx];
              res_next.listen_port = e_sport[hit_idx];
              res_next.remote_port = e_cport[hit_idx];
              res_next.syn_count   = 16'(rd_cnt);
              res_next.start_sec   = rd_start;
            end else begin
              res_next.kind        = KIND_DEL_MISS;
              res_next.listen_ip   = cur.listen_ip;
              res_next.remote_ip   = cur.remote_ip;
              res_next.listen_port = cur.listen_port;
              res_next.remote_port = cur.remote_port;
            end
          end
          OP_IGNORE, OP_SWEEP: begin
            res_next.kind = KIND_IGNORED;
          end
          default: begin
            res_next.kind = KIND_IGNORED;
          end
        endcase
      end
      ST_SWEEP: begin
        res_next.kind        = KIND_EXPIRED;
        res_next.listen_ip   = e_sip[idx];
        res_next.remote_ip   = e_cip[idx];
        res_next.listen_port = e_sport[idx];
        res_next.remote_port = e_cport[idx];
        res_next.syn_count   = 16'(rd_cnt);
        res_next.start_sec   = rd_start;
        res_next.last        = 1'b0;
      end
      ST_DONE: begin
        res_next.kind = KIND_SWEEP_DONE;
      end
      default: begin
        res_next.kind = KIND_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      valid      <= '0;
      used_count <= '0;
      detected   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      used_count <= used_count_next;
      detected   <= detected_next;
      if (do_add) begin
        valid[free_idx] <= 1'b1;
      end
      if (do_del) begin
        valid[hit_idx] <= 1'b0;
      end
      if (sweep_exp) begin
        valid[idx] <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (do_add) begin
      e_sip[free_idx]   <= cur.listen_ip;
      e_cip[free_idx]   <= cur.remote_ip;
      e_sport[free_idx] <= cur.listen_port;
      e_cport[free_idx] <= cur.remote_port;
      e_cnt[free_idx]   <= COUNT_BITS'(1);
      e_start[free_idx] <= cur.now_sec;
    end
    if (do_merge) begin
      e_cnt[hit_idx] <= cnt_inc;
    end
  end

  assign status.busy       = (state != ST_IDLE);
  assign status.used_count = used_count;

endmodule

`default_nettype wire

@@ src/tcp_half_open_tracker.sv @@
// packet: the transaction is queued, then popped into the command register, then the
// table compare and update load the result register once the output is free; the back
// end pops no command until that result is loaded; sweep: walks all 16 slots one per
// cycle, waiting at an expired slot for a free output, then gives the summary result
// synchronous active-high reset clears valid bits, counters and queue and resets config
// top level with config registers; depends on tho_pkg, tho_front, tho_queue, tho_back
`default_nettype none
`include "tcp_half_open_tracker_macros.svh"

module tcp_half_open_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tho_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tho_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tcp_flags, src_ip, dst_ip, src_port, dst_port, now_sec
  input  logic [tho_pkg::S_TDATA_W-1:0]   s_tdata,
  // cmd
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // listen_ip, remote_ip, listen_port, remote_port, syn_count, start_sec,
  // entries_in_use, detected_total, zero pad
  output logic [tho_pkg::M_TDATA_W-1:0]   m_tdata,
  // kind
  output logic [2:0]                      m_tuser,
  output logic                            m_tlast
);
  import tho_pkg::*;

  logic         monitor_enable;
  logic [15:0]  age_threshold_sec;
  logic         push;
  op_t          push_op;
  logic         queue_full;
  logic         queue_empty;
  logic         pop;
  op_t          head;
  res_t         res;
  back_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable    <= 1'b0;
      age_threshold_sec <= AGE_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MONITOR_ENABLE: monitor_enable    <= cfg_wdata[0];
        REG_AGE_THRESHOLD:  age_threshold_sec <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  tho_front u_front (
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .monitor_enable (monitor_enable),
    .queue_full     (queue_full),
    .push           (push),
    .push_op        (push_op)
  );

  tho_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (queue_full),
    .pop     (pop),
    .empty   (queue_empty),
    .head    (head)
  );

  tho_back u_back (
    .clk               (clk),
    .rst               (rst),
    .age_threshold_sec (age_threshold_sec),
    .q_empty           (queue_empty),
    .q_head            (head),
    .q_pop             (pop),
    .res_valid         (m_tvalid),
    .res_ready         (m_tready),
    .res               (res),
    .status            (status)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, res.detected_total, res.entries_in_use, res.start_sec,
                    res.syn_count, res.remote_port, res.listen_port, res.remote_ip,
                    res.listen_ip};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  `THO_ASSERT_ALWAYS(a_used_bound, status.used_count <= USED_W'(TABLE_ENTRIES))
  `THO_ASSERT_IMPLY(a_last_unless_expired, m_tvalid && (res.kind != KIND_EXPIRED), m_tlast)
  `THO_ASSERT_IMPLY(a_expired_counted, m_tvalid && (res.kind == KIND_EXPIRED),
                    res.detected_total != 32'd0)
  `THO_ASSERT_IMPLY(a_pop_only_idle, pop, !status.busy)

endmodule

`default_nettype wire
